// ----- hdl/fys_pkg.sv -----
// Shared types and constants of the shuffle engine.
package fys_pkg;

   localparam int MAX_ENTRIES = 64;
   localparam int IDX_W       = $clog2(MAX_ENTRIES);
   localparam int VAL_W       = 7;
   localparam int SIZE_W      = 7;
   localparam int WORD_W      = 32;
   localparam int ACT_W       = 2;
   localparam int CNT_W       = $clog2(WORD_W);

   localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(2);
   localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(MAX_ENTRIES);
   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(64);

   localparam logic [ACT_W-1:0] ACT_FILL   = 2'd0;
   localparam logic [ACT_W-1:0] ACT_STEP   = 2'd1;
   localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;
   localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

   typedef enum logic [1:0] {
      SEL_FILL,
      SEL_J,
      SEL_P,
      SEL_RIDX
   } addr_sel_type;

   typedef struct packed {
      logic         load;
      logic         div_step;
      logic         fill_step;
      logic         rd_en;
      logic         wr_en;
      logic         cap_tmp;
      logic         post;
      addr_sel_type addr_sel;
   } ctrl_cmd_type;

   typedef struct packed {
      logic div_last;
      logic fill_last;
      logic rsp_free;
   } ctrl_sts_type;

endpackage

// ----- hdl/fys_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module fys_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/fys_ctrl.sv -----
// Sequencing state machine of the shuffle engine.
module fys_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [fys_pkg::ACT_W-1:0]   req_action,
   input  fys_pkg::ctrl_sts_type       sts,
   output fys_pkg::ctrl_cmd_type       cmd
);
   import fys_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_FILL = 4'd1;
   localparam logic [3:0] S_DIV  = 4'd2;
   localparam logic [3:0] S_RDJ  = 4'd3;
   localparam logic [3:0] S_RDP  = 4'd4;
   localparam logic [3:0] S_WRJ  = 4'd5;
   localparam logic [3:0] S_WRP  = 4'd6;
   localparam logic [3:0] S_RDR  = 4'd7;
   localparam logic [3:0] S_POST = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      cmd.addr_sel = SEL_RIDX;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               unique case (req_action)
                  ACT_FILL: state_in = S_FILL;
                  ACT_STEP: state_in = S_DIV;
                  ACT_READ: state_in = S_RDR;
                  default:  state_in = S_POST;
               endcase
            end
         end
         S_FILL: begin
            cmd.wr_en     = 1'b1;
            cmd.fill_step = 1'b1;
            cmd.addr_sel  = SEL_FILL;
            if (sts.fill_last) begin
               state_in = S_POST;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = S_RDJ;
            end
         end
         S_RDJ: begin
            cmd.rd_en    = 1'b1;
            cmd.addr_sel = SEL_J;
            state_in     = S_RDP;
         end
         S_RDP: begin
            cmd.rd_en    = 1'b1;
            cmd.cap_tmp  = 1'b1;
            cmd.addr_sel = SEL_P;
            state_in     = S_WRJ;
         end
         S_WRJ: begin
            cmd.wr_en    = 1'b1;
            cmd.addr_sel = SEL_J;
            state_in     = S_WRP;
         end
         S_WRP: begin
            cmd.wr_en    = 1'b1;
            cmd.addr_sel = SEL_P;
            state_in     = S_POST;
         end
         S_RDR: begin
            cmd.rd_en    = 1'b1;
            cmd.addr_sel = SEL_RIDX;
            state_in     = S_POST;
         end
         S_POST: begin
            if (sts.rsp_free) begin
               cmd.post = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hdl/fys_datapath.sv -----
// Datapath: item registers, remainder unit, table RAM and result register.
module fys_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  fys_pkg::ctrl_cmd_type        cmd,
   output fys_pkg::ctrl_sts_type        sts,
   input  logic [fys_pkg::SIZE_W-1:0]   table_size,
   input  logic [fys_pkg::ACT_W-1:0]    req_action,
   input  logic [fys_pkg::WORD_W-1:0]   req_word,
   input  logic [fys_pkg::IDX_W-1:0]    req_index,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [fys_pkg::VAL_W-1:0]    rsp_value,
   output logic [fys_pkg::IDX_W-1:0]    rsp_position,
   output logic                         rsp_last
);
   import fys_pkg::*;

   logic [ACT_W-1:0]  act_ff, act_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic [IDX_W-1:0]  ridx_ff, ridx_in;
   logic [IDX_W-1:0]  p_ff, p_in;
   logic [SIZE_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]  div_cnt_ff, div_cnt_in;
   logic [IDX_W-1:0]  fill_cnt_ff, fill_cnt_in;
   logic [VAL_W-1:0]  tmp_ff, tmp_in;
   logic [IDX_W-1:0]  step_pos_ff, step_pos_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [IDX_W-1:0]  rsp_pos_ff, rsp_pos_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [SIZE_W-1:0] n_eff;
   logic [IDX_W-1:0]  n_last;
   logic [SIZE_W-1:0] divisor;
   logic [SIZE_W-1:0] trial;
   logic [IDX_W-1:0]  j_idx;
   logic [IDX_W-1:0]  wr_addr;
   logic [IDX_W-1:0]  rd_addr;
   logic [VAL_W-1:0]  wr_data;
   logic [VAL_W-1:0]  rd_data;
   logic              rsp_free;

   // Effective table size, clamped to the supported range.
   always_comb begin
      priority if (table_size < SIZE_MIN) begin
         n_eff = SIZE_MIN;
      end else if (table_size > SIZE_MAX) begin
         n_eff = SIZE_MAX;
      end else begin
         n_eff = table_size;
      end
   end

   assign n_last  = IDX_W'(n_eff - SIZE_W'(1));
   assign divisor = SIZE_W'({1'b0, p_ff}) + SIZE_W'(1);
   assign trial   = {rem_ff[IDX_W-1:0], word_ff[WORD_W-1]};
   assign j_idx   = rem_ff[IDX_W-1:0];
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // Item capture, restoring remainder, fill counter and swap temporary.
   always_comb begin
      act_in      = act_ff;
      word_in     = word_ff;
      ridx_in     = ridx_ff;
      p_in        = p_ff;
      rem_in      = rem_ff;
      div_cnt_in  = div_cnt_ff;
      fill_cnt_in = fill_cnt_ff;
      tmp_in      = tmp_ff;
      if (cmd.load) begin
         act_in      = req_action;
         word_in     = req_word;
         ridx_in     = req_index;
         rem_in      = '0;
         div_cnt_in  = '0;
         fill_cnt_in = '0;
         // A stale position from an earlier, larger size restarts the pass.
         if (SIZE_W'({1'b0, step_pos_ff}) >= n_eff || step_pos_ff == '0) begin
            p_in = n_last;
         end else begin
            p_in = step_pos_ff;
         end
      end
      if (cmd.div_step) begin
         word_in    = {word_ff[WORD_W-2:0], 1'b0};
         div_cnt_in = div_cnt_ff + CNT_W'(1);
         if (trial >= divisor) begin
            rem_in = trial - divisor;
         end else begin
            rem_in = trial;
         end
      end
      if (cmd.fill_step) begin
         fill_cnt_in = fill_cnt_ff + IDX_W'(1);
      end
      if (cmd.cap_tmp) begin
         tmp_in = rd_data;
      end
   end

   // Table RAM addressing.
   always_comb begin
      wr_addr = fill_cnt_ff;
      wr_data = VAL_W'({1'b0, fill_cnt_ff}) + VAL_W'(1);
      rd_addr = ridx_ff;
      unique case (cmd.addr_sel)
         SEL_FILL: begin
            wr_addr = fill_cnt_ff;
            wr_data = VAL_W'({1'b0, fill_cnt_ff}) + VAL_W'(1);
         end
         SEL_J: begin
            wr_addr = j_idx;
            wr_data = rd_data;
            rd_addr = j_idx;
         end
         SEL_P: begin
            wr_addr = p_ff;
            wr_data = tmp_ff;
            rd_addr = p_ff;
         end
         SEL_RIDX: begin
            rd_addr = ridx_ff;
         end
         default: begin
            rd_addr = ridx_ff;
         end
      endcase
   end

   fys_ram #(
      .WIDTH (VAL_W),
      .DEPTH (MAX_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Result register and step position update.
   always_comb begin
      step_pos_in  = step_pos_ff;
      rsp_value_in = rsp_value_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.post) begin
         rsp_valid_in = 1'b1;
         unique case (act_ff)
            ACT_FILL: begin
               rsp_value_in = '0;
               rsp_pos_in   = n_last;
               rsp_last_in  = 1'b1;
               step_pos_in  = n_last;
            end
            ACT_STEP: begin
               rsp_value_in = tmp_ff;
               rsp_pos_in   = p_ff;
               rsp_last_in  = (p_ff == IDX_W'(1));
               step_pos_in  = (p_ff == IDX_W'(1)) ? n_last : p_ff - IDX_W'(1);
            end
            ACT_READ: begin
               rsp_value_in = rd_data;
               rsp_pos_in   = ridx_ff;
               rsp_last_in  = 1'b0;
            end
            default: begin
               rsp_value_in = '0;
               rsp_pos_in   = '0;
               rsp_last_in  = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_pos_ff  <= IDX_W'(SIZE_RESET - SIZE_W'(1));
         rsp_valid_ff <= 1'b0;
      end else begin
         step_pos_ff  <= step_pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff       <= act_in;
      word_ff      <= word_in;
      ridx_ff      <= ridx_in;
      p_ff         <= p_in;
      rem_ff       <= rem_in;
      div_cnt_ff   <= div_cnt_in;
      fill_cnt_ff  <= fill_cnt_in;
      tmp_ff       <= tmp_in;
      rsp_value_ff <= rsp_value_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign sts.div_last  = (div_cnt_ff == CNT_W'(WORD_W - 1));
   assign sts.fill_last = (SIZE_W'({1'b0, fill_cnt_ff}) == SIZE_W'({1'b0, n_last}));
   assign sts.rsp_free  = rsp_free;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_position = rsp_pos_ff;
   assign rsp_last     = rsp_last_ff;

   // The partial remainder never reaches the divisor.
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |=> rem_ff <= SIZE_W'({1'b0, $past(p_ff)}))
      else $error("shuffle remainder out of range");

   // A step always works on a position inside the table, never on zero.
   a_step_pos_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> (p_ff != '0) && (SIZE_W'({1'b0, p_ff}) < n_eff))
      else $error("shuffle position outside table");

   // A new result is never loaded over one that has not been transferred.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.post |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten");

   // After a step the position moves down by one, or wraps at position one.
   a_step_advance: assert property (@(posedge clock) disable iff (reset)
      (cmd.post && act_ff == ACT_STEP && p_ff != IDX_W'(1))
         |=> step_pos_ff == $past(p_ff) - IDX_W'(1))
      else $error("step position did not advance");

endmodule

// ----- hdl/fisher_yates_shuffle_engine.sv -----
// Top level of the step-wise Fisher-Yates shuffle engine.
// A step runs the remainder unit, reads entries j and p, writes them back
// swapped and posts; a read posts one entry, a fill writes n entries. No request
// is taken until the result is posted. Step time is set by the remainder unit
// (one quotient bit per cycle over the 32-bit random word) and the table RAM
// (two reads, two writes). Reset (synchronous) clears the controller and the
// result valid flag, sets size 64 and step position 63; table stays until a fill.
module fisher_yates_shuffle_engine (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // random_word[31:0], read_index[37:32], zero[39:38]
   input  logic [1:0]  req_tuser,  // action[1:0]
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // entry_value[6:0], position[12:7], zero[15:13]
   output logic        rsp_tlast,  // last_of_pass
   // Table size register write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [6:0]  csr_data    // table_size
);
   import fys_pkg::*;

   logic [SIZE_W-1:0]  table_size_ff;
   logic [SIZE_W-1:0]  table_size_in;
   ctrl_cmd_type       cmd;
   ctrl_sts_type       sts;
   logic [VAL_W-1:0]   rsp_value;
   logic [IDX_W-1:0]   rsp_position;

   // The size register accepts a transfer in every cycle. The user must write it only
   // while the engine is idle, so no item ever sees it change; this is not enforced.
   assign csr_ready = 1'b1;

   always_comb begin
      table_size_in = table_size_ff;
      if (csr_valid && csr_ready) begin
         table_size_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= SIZE_RESET;
      end else begin
         table_size_ff <= table_size_in;
      end
   end

   // The controller sequences fill, remainder, swap and read operations.
   fys_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_action (req_tuser),
      .sts        (sts),
      .cmd        (cmd)
   );

   // The datapath owns the table, the remainder unit and the result register,
   // so a finished result can wait while the next request is transferred.
   fys_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .table_size   (table_size_ff),
      .req_action   (req_tuser),
      .req_word     (req_tdata[WORD_W-1:0]),
      .req_index    (req_tdata[WORD_W+IDX_W-1:WORD_W]),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_value    (rsp_value),
      .rsp_position (rsp_position),
      .rsp_last     (rsp_tlast)
   );

   assign rsp_tdata = {3'b000, rsp_position, rsp_value};

endmodule
